// ===== rtl/core/rrss_pkg.sv =====
// Shared types and constants for the round-robin slice scheduler.
package rrss_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int TIME_W            = 16;
  localparam int FIELD_W           = 12;
  localparam int PID_W             = 16;
  localparam int REPIDX_W          = 4;
  localparam int WSUM_W            = 20;
  localparam int PCOUNT_W          = 5;
  localparam int QUANTUM_RST       = 2;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STEP   = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_LOAD   = 3'd0,
    KIND_SLICE  = 3'd1,
    KIND_IDLE   = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_REPORT = 3'd4,
    KIND_REJECT = 3'd5
  } kind_t;

  typedef struct packed {
    action_t              action;
    logic [PID_W-1:0]     process_id;
    logic [FIELD_W-1:0]   arrival_time;
    logic [FIELD_W-1:0]   burst_length;
    logic [REPIDX_W-1:0]  report_index;
  } in_item_t;

  typedef struct packed {
    kind_t                kind;
    logic [PID_W-1:0]     slice_pid;
    logic [TIME_W-1:0]    start_time;
    logic [TIME_W-1:0]    end_time;
    logic                 finished;
    logic                 new_chart_entry;
    logic [TIME_W-1:0]    turnaround;
    logic [TIME_W-1:0]    waiting;
    logic [WSUM_W-1:0]    total_waiting;
    logic [PCOUNT_W-1:0]  process_count;
  } out_item_t;

  // One row of the process table.
  typedef struct packed {
    logic [PID_W-1:0]     id;
    logic [FIELD_W-1:0]   arrival;
    logic [FIELD_W-1:0]   burst;
    logic [FIELD_W-1:0]   remaining;
    logic [TIME_W-1:0]    completion;
  } entry_t;

endpackage

// ===== rtl/core/rrss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rrss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/rrss_seq.sv =====
// Sequencer: scans the process table memory, runs slices and builds results.
module rrss_seq #(
  parameter int MAX_PROCESSES = rrss_pkg::MAX_PROCESSES_DEF,
  localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
  localparam int EW = $bits(rrss_pkg::entry_t)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rrss_pkg::FIELD_W-1:0]    quantum,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rrss_pkg::in_item_t              in_item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output rrss_pkg::out_item_t             res_item,
  output logic                            ram_wr_en,
  output logic [IW-1:0]                   ram_wr_addr,
  output logic [EW-1:0]                   ram_wr_data,
  output logic [IW-1:0]                   ram_rd_addr,
  input  logic [EW-1:0]                   ram_rd_data
);

  import rrss_pkg::*;

  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam int XW = (CW > REPIDX_W) ? CW : REPIDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GAP,
    S_RUN,
    S_WAIT,
    S_REPORT,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       loaded_r;
  logic [CW-1:0]       pending_r;
  logic [TIME_W-1:0]   time_r;
  logic [IW-1:0]       scan_pos_r;
  logic                ran_any_r;
  logic [PID_W-1:0]    last_pid_r;
  logic                chart_started_r;
  logic [WSUM_W-1:0]   wsum_r;

  logic [CW-1:0]       issue_r;
  logic                chk_v_r;
  logic [IW-1:0]       chk_idx_r;
  logic [IW-1:0]       run_idx_r;
  entry_t              ent_r;
  logic                gap_any_r;
  logic [FIELD_W-1:0]  gap_min_r;
  logic [TIME_W-1:0]   tat_r;
  out_item_t           res_r;

  entry_t              rd_ent;
  logic                accept;
  logic                issue_ok;
  logic                elig;
  logic [FIELD_W-1:0]  q_eff;
  logic [FIELD_W-1:0]  run_len;
  logic [TIME_W:0]     time_sum;
  logic [TIME_W-1:0]   new_time;
  logic [FIELD_W-1:0]  rem_new;
  logic [CW-1:0]       next_idx;
  logic [FIELD_W-1:0]  load_burst;
  logic [XW-1:0]       rep_idx_x;
  logic [XW-1:0]       loaded_x;
  logic [TIME_W-1:0]   gap_time;
  logic [TIME_W-1:0]   wait_len;
  logic [WSUM_W:0]     wsum_sum;
  logic [TIME_W-1:0]   rep_tat;
  entry_t              upd_ent;
  entry_t              new_ent;

  assign rd_ent    = entry_t'(ram_rd_data);
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign issue_ok  = (issue_r < loaded_r);
  assign elig      = chk_v_r && (rd_ent.remaining != '0) &&
                     ({{(TIME_W-FIELD_W){1'b0}}, rd_ent.arrival} <= time_r);

  // slice arithmetic on the captured entry
  assign q_eff     = (quantum == '0) ? FIELD_W'(1) : quantum;
  assign run_len   = (ent_r.remaining > q_eff) ? q_eff : ent_r.remaining;
  assign time_sum  = {1'b0, time_r} + (TIME_W+1)'(run_len);
  assign new_time  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
  assign rem_new   = ent_r.remaining - run_len;
  assign next_idx  = CW'(run_idx_r) + CW'(1);

  assign load_burst = (in_item.burst_length == '0) ? FIELD_W'(1) : in_item.burst_length;
  assign rep_idx_x  = XW'(in_item.report_index);
  assign loaded_x   = XW'(loaded_r);

  assign gap_time = (gap_any_r && ({{(TIME_W-FIELD_W){1'b0}}, gap_min_r} > time_r)) ?
                    {{(TIME_W-FIELD_W){1'b0}}, gap_min_r} :
                    ((time_r != '1) ? time_r + TIME_W'(1) : time_r);

  assign wait_len = (tat_r > {{(TIME_W-FIELD_W){1'b0}}, ent_r.burst}) ?
                    tat_r - {{(TIME_W-FIELD_W){1'b0}}, ent_r.burst} : '0;
  assign wsum_sum = {1'b0, wsum_r} + (WSUM_W+1)'(wait_len);

  assign rep_tat  = rd_ent.completion - {{(TIME_W-FIELD_W){1'b0}}, rd_ent.arrival};

  always_comb begin
    upd_ent            = ent_r;
    upd_ent.remaining  = rem_new;
    if (rem_new == '0) begin
      upd_ent.completion = new_time;
    end
    new_ent            = '0;
    new_ent.id         = in_item.process_id;
    new_ent.arrival    = in_item.arrival_time;
    new_ent.burst      = load_burst;
    new_ent.remaining  = load_burst;
  end

  // One item in flight at a time: a write-back in S_RUN never overlaps a read
  // of the same row, so no forwarding path is needed.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = run_idx_r;
    ram_wr_data = EW'(upd_ent);
    ram_rd_addr = issue_r[IW-1:0];
    if (state_r == S_IDLE) begin
      ram_rd_addr = IW'(in_item.report_index);
      if (accept && in_item.action == ACT_LOAD && loaded_r < CW'(MAX_PROCESSES)) begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = loaded_r[IW-1:0];
        ram_wr_data = EW'(new_ent);
      end
    end else if (state_r == S_RUN) begin
      ram_wr_en = 1'b1;
    end
  end

  always_comb begin
    res_item               = res_r;
    res_item.total_waiting = wsum_r;
    res_item.process_count = PCOUNT_W'(loaded_r);
  end

  assign res_valid = (state_r == S_DONE);

  // res_r is all zero whenever the sequencer is idle; each item fills in its fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      loaded_r        <= '0;
      pending_r       <= '0;
      time_r          <= '0;
      scan_pos_r      <= '0;
      ran_any_r       <= 1'b0;
      last_pid_r      <= '0;
      chart_started_r <= 1'b0;
      wsum_r          <= '0;
      issue_r         <= '0;
      chk_v_r         <= 1'b0;
      gap_any_r       <= 1'b0;
      res_r           <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_item.action)
              ACT_CLEAR: begin
                loaded_r        <= '0;
                pending_r       <= '0;
                time_r          <= '0;
                scan_pos_r      <= '0;
                ran_any_r       <= 1'b0;
                last_pid_r      <= '0;
                chart_started_r <= 1'b0;
                wsum_r          <= '0;
              end
              ACT_LOAD: begin
                if (loaded_r >= CW'(MAX_PROCESSES)) begin
                  res_r.kind <= KIND_REJECT;
                end else begin
                  res_r.kind      <= KIND_LOAD;
                  res_r.slice_pid <= in_item.process_id;
                  loaded_r        <= loaded_r + CW'(1);
                  pending_r       <= pending_r + CW'(1);
                end
                state_r <= S_DONE;
              end
              ACT_STEP: begin
                if (pending_r == '0) begin
                  res_r.kind       <= KIND_DONE;
                  res_r.start_time <= time_r;
                  res_r.end_time   <= time_r;
                  state_r          <= S_DONE;
                end else begin
                  issue_r <= CW'(scan_pos_r);
                  chk_v_r <= 1'b0;
                  state_r <= S_SCAN;
                end
              end
              ACT_REPORT: begin
                if (rep_idx_x >= loaded_x) begin
                  res_r.kind <= KIND_REJECT;
                  state_r    <= S_DONE;
                end else begin
                  state_r <= S_REPORT;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_SCAN: begin
          if (elig) begin
            ent_r     <= rd_ent;
            run_idx_r <= chk_idx_r;
            chk_v_r   <= 1'b0;
            state_r   <= S_RUN;
          end else if (!chk_v_r && !issue_ok) begin
            issue_r <= '0;
            if (ran_any_r) begin
              // wrap to a fresh pass inside the same step
              ran_any_r  <= 1'b0;
              scan_pos_r <= '0;
            end else begin
              gap_any_r <= 1'b0;
              state_r   <= S_GAP;
            end
          end else begin
            chk_v_r   <= issue_ok;
            chk_idx_r <= issue_r[IW-1:0];
            if (issue_ok) begin
              issue_r <= issue_r + CW'(1);
            end
          end
        end

        S_GAP: begin
          // earliest arrival among unfinished processes
          if (chk_v_r && rd_ent.remaining != '0 &&
              (!gap_any_r || rd_ent.arrival < gap_min_r)) begin
            gap_min_r <= rd_ent.arrival;
            gap_any_r <= 1'b1;
          end
          if (!chk_v_r && !issue_ok) begin
            res_r.kind       <= KIND_IDLE;
            res_r.start_time <= time_r;
            res_r.end_time   <= gap_time;
            time_r           <= gap_time;
            scan_pos_r       <= '0;
            ran_any_r        <= 1'b0;
            state_r          <= S_DONE;
          end else begin
            chk_v_r   <= issue_ok;
            chk_idx_r <= issue_r[IW-1:0];
            if (issue_ok) begin
              issue_r <= issue_r + CW'(1);
            end
          end
        end

        S_RUN: begin
          res_r.kind            <= KIND_SLICE;
          res_r.slice_pid       <= ent_r.id;
          res_r.start_time      <= time_r;
          res_r.end_time        <= new_time;
          res_r.finished        <= (rem_new == '0);
          res_r.new_chart_entry <= !chart_started_r || (last_pid_r != ent_r.id);
          chart_started_r       <= 1'b1;
          last_pid_r            <= ent_r.id;
          time_r                <= new_time;
          tat_r                 <= new_time - {{(TIME_W-FIELD_W){1'b0}}, ent_r.arrival};
          if (next_idx >= loaded_r) begin
            scan_pos_r <= '0;
            ran_any_r  <= 1'b0;
          end else begin
            scan_pos_r <= next_idx[IW-1:0];
            ran_any_r  <= 1'b1;
          end
          if (rem_new == '0) begin
            if (pending_r != '0) begin
              pending_r <= pending_r - CW'(1);
            end
            state_r <= S_WAIT;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_WAIT: begin
          wsum_r  <= wsum_sum[WSUM_W] ? '1 : wsum_sum[WSUM_W-1:0];
          state_r <= S_DONE;
        end

        S_REPORT: begin
          res_r.kind      <= KIND_REPORT;
          res_r.slice_pid <= rd_ent.id;
          if (rd_ent.remaining == '0) begin
            res_r.end_time   <= rd_ent.completion;
            res_r.finished   <= 1'b1;
            res_r.turnaround <= rep_tat;
            res_r.waiting    <= (rep_tat > {{(TIME_W-FIELD_W){1'b0}}, rd_ent.burst}) ?
                                rep_tat - {{(TIME_W-FIELD_W){1'b0}}, rd_ent.burst} : '0;
          end
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (res_ready) begin
            res_r   <= '0;
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rrss_obuf.sv =====
// Output holding register between the sequencer and the result channel.
module rrss_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  rrss_pkg::out_item_t  res_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rrss_pkg::out_item_t  out_item
);

  import rrss_pkg::*;

  logic      out_valid_r;
  out_item_t out_item_r;

  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item_r <= res_item;
    end
  end

endmodule

// ===== rtl/core/round_robin_slice_scheduler_core.sv =====
// Load, report, reject and all-done items pass from the sequencer's result register
// to the output register. A step item reads the process table one row per cycle
// through its single read port, scanning rows (with a second pass on wrap, or a full
// sweep on an idle jump) before its result is registered. One item is worked at a time.
// Synchronous active-low reset clears counters, time and scan state and sets the
// quantum to 2; table rows are undefined until loaded, so no clearing pass runs.
module round_robin_slice_scheduler_core #(
  parameter int MAX_PROCESSES = rrss_pkg::MAX_PROCESSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rrss_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rrss_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrss_pkg::FIELD_W-1:0]  cfg_data
);

  import rrss_pkg::*;

  localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int EW = $bits(entry_t);

  logic [FIELD_W-1:0] quantum_r;
  logic               res_valid;
  logic               res_ready;
  out_item_t          res_item;
  logic               ram_wr_en;
  logic [IW-1:0]      ram_wr_addr;
  logic [EW-1:0]      ram_wr_data;
  logic [IW-1:0]      ram_rd_addr;
  logic [EW-1:0]      ram_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= FIELD_W'(QUANTUM_RST);
    end else if (cfg_valid && cfg_ready) begin
      quantum_r <= cfg_data;
    end
  end

  rrss_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PROCESSES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  rrss_seq #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .quantum     (quantum_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  rrss_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
